// ===== hdl/tdmd_pkg.sv =====
// ----------------------------------------------------------------------------
// tdmd_pkg
// Shared types and constants for the timed dual motor drive.
// ----------------------------------------------------------------------------
package tdmd_pkg;

  localparam int TIME_BITS_DEF = 16;
  localparam int FUNC_W        = 3;
  localparam int DUR_W         = 16;
  localparam int POWER_W       = 8;
  localparam int ELAPSED_W     = 10;
  localparam int IN_DATA_W     = 48;
  localparam int OUT_DATA_W    = 40;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK        = 3'd0,
    FUNC_FORWARD     = 3'd1,
    FUNC_BACK        = 3'd2,
    FUNC_TURN        = 3'd3,
    FUNC_HALT        = 3'd4,
    FUNC_UNLOCK      = 3'd5,
    FUNC_FLASH_START = 3'd6,
    FUNC_FLASH_STOP  = 3'd7
  } func_e;

  typedef struct packed {
    func_e                    func;
    logic signed [DUR_W-1:0]  duration;
    logic [POWER_W-1:0]       left_power;
    logic [POWER_W-1:0]       right_power;
    logic                     left_forward;
    logic                     right_forward;
    logic [ELAPSED_W-1:0]     elapsed;
  } cmd_t;

  typedef struct packed {
    logic [POWER_W-1:0] left_a_duty;
    logic [POWER_W-1:0] left_b_duty;
    logic [POWER_W-1:0] right_a_duty;
    logic [POWER_W-1:0] right_b_duty;
    logic               rear_led;
    logic               finished;
    logic               locked;
  } res_t;

  // mode flags, left_fwd in the lowest bit
  typedef struct packed {
    logic led;
    logic flash;
    logic locked;
    logic right_fwd;
    logic left_fwd;
  } flags_t;

endpackage

// ===== hdl/tdmd_in_stage.sv =====
// ----------------------------------------------------------------------------
// tdmd_in_stage
// Input register: unpacks the incoming word and holds it until the core
// takes it.
// ----------------------------------------------------------------------------
module tdmd_in_stage
  import tdmd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic [IN_DATA_W-1:0] data_i,
  input  logic [FUNC_W-1:0]    user_i,
  input  logic                 adv_i,
  output logic                 valid_o,
  output cmd_t                 cmd_o
);

  logic valid_q, valid_d;
  cmd_t cmd_q;
  logic load;

  assign ready_o = !valid_q || adv_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q.func          <= func_e'(user_i);
      cmd_q.duration      <= signed'(data_i[15:0]);
      cmd_q.left_power    <= data_i[23:16];
      cmd_q.right_power   <= data_i[31:24];
      cmd_q.left_forward  <= data_i[32];
      cmd_q.right_forward <= data_i[33];
      cmd_q.elapsed       <= data_i[43:34];
    end
  end

  assign valid_o = valid_q;
  assign cmd_o   = cmd_q;

endmodule

// ===== hdl/tdmd_core.sv =====
// ----------------------------------------------------------------------------
// tdmd_core
// Move and flash state with the single-pass next-state and drive logic.
// ----------------------------------------------------------------------------
module tdmd_core
  import tdmd_pkg::*;
#(
  parameter int TimeBits = TIME_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic adv_i,
  input  cmd_t cmd_i,
  output res_t res_o
);

  localparam int WW = ((TimeBits > DUR_W) ? TimeBits : DUR_W) + 2;
  localparam logic signed [WW-1:0] TMinW =
    signed'({{(WW-TimeBits+1){1'b1}}, {(TimeBits-1){1'b0}}});
  localparam logic signed [WW-1:0] TMaxW =
    signed'({{(WW-TimeBits+1){1'b0}}, {(TimeBits-1){1'b1}}});
  localparam int Msb = TimeBits - 1;

  logic signed [TimeBits-1:0] rem_q, rem_d;
  logic signed [TimeBits-1:0] fcnt_q, fcnt_d;
  logic signed [TimeBits-1:0] fper_q, fper_d;
  logic [POWER_W-1:0]         ldu_q, ldu_d;
  logic [POWER_W-1:0]         rdu_q, rdu_d;
  flags_t                     flags_q, flags_d;
  logic signed [TimeBits-1:0] dur;
  logic                       drive_on;

  // subtract, saturating at the most negative value
  function automatic logic signed [TimeBits-1:0] sat_sub(
    input logic signed [TimeBits-1:0] v,
    input logic [ELAPSED_W-1:0]       e
  );
    logic signed [WW-1:0] w;
    w = signed'({{(WW-TimeBits){v[TimeBits-1]}}, v})
      - signed'({{(WW-ELAPSED_W){1'b0}}, e});
    if (w < TMinW) begin
      return TMinW[TimeBits-1:0];
    end
    return w[TimeBits-1:0];
  endfunction

  function automatic logic signed [TimeBits-1:0] clamp_dur(
    input logic signed [DUR_W-1:0] d
  );
    logic signed [WW-1:0] w;
    w = signed'({{(WW-DUR_W){d[DUR_W-1]}}, d});
    if (w < TMinW) begin
      return TMinW[TimeBits-1:0];
    end else if (w > TMaxW) begin
      return TMaxW[TimeBits-1:0];
    end
    return w[TimeBits-1:0];
  endfunction

  assign dur = clamp_dur(cmd_i.duration);

  always_comb begin
    rem_d   = rem_q;
    fcnt_d  = fcnt_q;
    fper_d  = fper_q;
    ldu_d   = ldu_q;
    rdu_d   = rdu_q;
    flags_d = flags_q;
    unique case (cmd_i.func)
      FUNC_TICK: begin
        if (!rem_q[Msb]) begin
          rem_d = sat_sub(rem_q, cmd_i.elapsed);
        end
        if (rem_d[Msb] || (rem_d == '0)) begin
          flags_d.locked = 1'b0;
        end
        if (flags_q.flash) begin
          if (fcnt_q[Msb] || (fcnt_q == '0)) begin
            fcnt_d      = fper_q;
            flags_d.led = !flags_q.led;
          end else begin
            fcnt_d = sat_sub(fcnt_q, cmd_i.elapsed);
          end
        end
      end
      FUNC_FORWARD: begin
        if (!flags_q.locked) begin
          ldu_d             = cmd_i.left_power;
          rdu_d             = cmd_i.left_power;
          flags_d.left_fwd  = 1'b1;
          flags_d.right_fwd = 1'b1;
          flags_d.locked    = 1'b1;
          rem_d             = dur;
        end
      end
      FUNC_BACK: begin
        ldu_d             = cmd_i.left_power;
        rdu_d             = cmd_i.left_power;
        flags_d.left_fwd  = 1'b0;
        flags_d.right_fwd = 1'b0;
        flags_d.locked    = 1'b1;
        rem_d             = dur;
      end
      FUNC_TURN: begin
        if (!flags_q.locked) begin
          ldu_d             = cmd_i.left_power;
          rdu_d             = cmd_i.right_power;
          flags_d.left_fwd  = cmd_i.left_forward;
          flags_d.right_fwd = cmd_i.right_forward;
          flags_d.locked    = 1'b1;
          rem_d             = dur;
        end
      end
      FUNC_HALT: begin
        flags_d = '0;
      end
      FUNC_UNLOCK: begin
        flags_d.locked = 1'b0;
      end
      FUNC_FLASH_START: begin
        flags_d.flash = 1'b1;
        fcnt_d        = dur;
        fper_d        = dur;
      end
      FUNC_FLASH_STOP: begin
        fper_d        = '0;
        flags_d.flash = 1'b0;
        flags_d.led   = 1'b0;
      end
    endcase
  end

  // a tick drives from the time before the subtraction
  assign drive_on = (cmd_i.func == FUNC_TICK) ? !rem_q[Msb] : !rem_d[Msb];

  always_comb begin
    res_o.left_a_duty  = (drive_on && !flags_d.left_fwd)  ? ldu_d : '0;
    res_o.left_b_duty  = (drive_on &&  flags_d.left_fwd)  ? ldu_d : '0;
    res_o.right_a_duty = (drive_on && !flags_d.right_fwd) ? rdu_d : '0;
    res_o.right_b_duty = (drive_on &&  flags_d.right_fwd) ? rdu_d : '0;
    res_o.rear_led     = flags_d.led;
    res_o.finished     = rem_d[Msb] || (rem_d == '0);
    res_o.locked       = flags_d.locked;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q   <= '1;
      fcnt_q  <= '0;
      fper_q  <= '0;
      ldu_q   <= '0;
      rdu_q   <= '0;
      flags_q <= '0;
    end else if (adv_i) begin
      rem_q   <= rem_d;
      fcnt_q  <= fcnt_d;
      fper_q  <= fper_d;
      ldu_q   <= ldu_d;
      rdu_q   <= rdu_d;
      flags_q <= flags_d;
    end
  end

endmodule

// ===== hdl/tdmd_out_stage.sv =====
// ----------------------------------------------------------------------------
// tdmd_out_stage
// Result register: holds one packed result word until the sink takes it.
// ----------------------------------------------------------------------------
module tdmd_out_stage
  import tdmd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  res_t                  res_i,
  output logic                  adv_o,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [OUT_DATA_W-1:0] data_o
);

  logic                  valid_q, valid_d;
  logic [OUT_DATA_W-1:0] data_q;

  assign adv_o = in_valid_i && (!valid_q || ready_i);

  always_comb begin
    valid_d = valid_q;
    if (adv_o) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      data_q <= {5'b0, res_i.locked, res_i.finished, res_i.rear_led,
                 res_i.right_b_duty, res_i.right_a_duty,
                 res_i.left_b_duty, res_i.left_a_duty};
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== hdl/timed_dual_motor_drive.sv =====
// ----------------------------------------------------------------------------
// timed_dual_motor_drive
// Timed moves for two H-bridge motors plus a flashing rear LED.
// ----------------------------------------------------------------------------
// Commands and elapsed-time ticks arrive on the s_axis channel, the kind of
// word in tuser and its arguments in tdata. Each accepted word gives exactly
// one result word on m_axis: four leg duties and the LED, finished and
// locked levels.
// An accepted word is held in the input register, passes through the core and
// is shown on m_axis from the result register. Throughput: one word per cycle
// while the sink does not stall, set by the single pass through the core.
// A result waiting on a stalled sink does not block the input register, so
// one more word is taken before s_axis_tready drops; nothing is lost.
// Reset clears both registers' valid flags and loads the move state:
// remaining time minus one, duties, flags and flash timer zero. The block
// takes words from the first cycle after reset.
// ----------------------------------------------------------------------------
module timed_dual_motor_drive
  import tdmd_pkg::*;
#(
  parameter int TimeBits = TIME_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // duration[15:0], left_power[23:16], right_power[31:24],
  // left_forward[32], right_forward[33], elapsed[43:34], zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // func[2:0]
  input  logic [FUNC_W-1:0]     s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // left_a_duty[7:0], left_b_duty[15:8], right_a_duty[23:16],
  // right_b_duty[31:24], rear_led[32], finished[33], locked[34], zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic in_valid;
  logic adv;
  cmd_t cmd;
  res_t res;

  tdmd_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .data_i  (s_axis_tdata),
    .user_i  (s_axis_tuser),
    .adv_i   (adv),
    .valid_o (in_valid),
    .cmd_o   (cmd)
  );

  tdmd_core #(
    .TimeBits (TimeBits)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .cmd_i  (cmd),
    .res_o  (res)
  );

  tdmd_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .res_i      (res),
    .adv_o      (adv),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .data_o     (m_axis_tdata)
  );

endmodule

// ===== hdl/tdmd_checker.sv =====
// ----------------------------------------------------------------------------
// tdmd_checker
// Port-level checks on the timed dual motor drive, bound to the top level.
// ----------------------------------------------------------------------------
module tdmd_checker
  import tdmd_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // a motor never drives both legs at once
  a_left_legs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[7:0] != 8'd0) |-> (m_axis_tdata[15:8] == 8'd0))
    else $error("left motor drives both legs");

  a_right_legs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[23:16] != 8'd0) |-> (m_axis_tdata[31:24] == 8'd0))
    else $error("right motor drives both legs");

  // a fresh result always comes from an accepted input word
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result word without an accepted input word");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result word changed or dropped");

endmodule

bind timed_dual_motor_drive tdmd_checker u_tdmd_checker (.*);

// ===== tb/sv/timed_dual_motor_drive_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_dual_motor_drive_checker
// Watches both stream channels, predicts each result word and compares it.
// ----------------------------------------------------------------------------
// Every word taken on the input side is run through a cycle-free model of the
// motor drive. The predicted result word is queued. Each result word taken on
// the output side is compared with the oldest queued word, field by field.
// ----------------------------------------------------------------------------
module timed_dual_motor_drive_checker
  import tdmd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid_i,
  input  logic                  s_tready_i,
  input  logic [IN_DATA_W-1:0]  s_tdata_i,
  input  logic [FUNC_W-1:0]     s_tuser_i,
  input  logic                  m_tvalid_i,
  input  logic                  m_tready_i,
  input  logic [OUT_DATA_W-1:0] m_tdata_i,
  output int                    errors_o,
  output int                    pending_o,
  output int                    words_checked_o
);

  localparam int TB    = TIME_BITS_DEF;
  localparam int T_MIN = -(1 << (TB - 1));
  localparam int T_MAX = (1 << (TB - 1)) - 1;

  // model state
  logic signed [TB-1:0] time_left;
  logic [POWER_W-1:0]   duty_l;
  logic [POWER_W-1:0]   duty_r;
  flags_t               mode;
  logic signed [TB-1:0] flash_cnt;
  logic signed [TB-1:0] flash_per;

  res_t expected_words[$];

  function automatic int clamp_time(int v);
    if (v < T_MIN) return T_MIN;
    if (v > T_MAX) return T_MAX;
    return v;
  endfunction

  // forward motor drives its B leg, reversed motor its A leg
  function automatic res_t leg_duties(bit active);
    res_t r;
    r = '0;
    if (active) begin
      if (mode.left_fwd) r.left_b_duty = duty_l;
      else r.left_a_duty = duty_l;
      if (mode.right_fwd) r.right_b_duty = duty_r;
      else r.right_a_duty = duty_r;
    end
    return r;
  endfunction

  function automatic res_t next_motor_word(cmd_t c);
    res_t                 r;
    logic signed [TB-1:0] dur;
    int                   el;
    r   = '0;
    el  = int'(c.elapsed);
    dur = TB'(clamp_time(int'($signed(c.duration))));
    case (c.func)
      FUNC_TICK: begin
        // legs follow the time left before this tick's elapsed time is taken off
        r = leg_duties(time_left >= 0);
        if (time_left >= 0) time_left = TB'(clamp_time(int'(time_left) - el));
        if (time_left <= 0) mode.locked = 1'b0;
        if (mode.flash) begin
          if (flash_cnt <= 0) begin
            flash_cnt = flash_per;
            mode.led  = ~mode.led;
          end else begin
            flash_cnt = TB'(clamp_time(int'(flash_cnt) - el));
          end
        end
      end
      FUNC_FORWARD: begin
        if (!mode.locked) begin
          duty_l         = c.left_power;
          duty_r         = c.left_power;
          mode.left_fwd  = 1'b1;
          mode.right_fwd = 1'b1;
          mode.locked    = 1'b1;
          time_left      = dur;
        end
      end
      FUNC_BACK: begin
        duty_l         = c.left_power;
        duty_r         = c.left_power;
        mode.left_fwd  = 1'b0;
        mode.right_fwd = 1'b0;
        mode.locked    = 1'b1;
        time_left      = dur;
      end
      FUNC_TURN: begin
        if (!mode.locked) begin
          time_left      = dur;
          duty_l         = c.left_power;
          duty_r         = c.right_power;
          mode.left_fwd  = c.left_forward;
          mode.right_fwd = c.right_forward;
          mode.locked    = 1'b1;
        end
      end
      FUNC_HALT:   mode = '0;
      FUNC_UNLOCK: mode.locked = 1'b0;
      FUNC_FLASH_START: begin
        mode.flash = 1'b1;
        flash_cnt  = dur;
        flash_per  = dur;
      end
      default: begin
        flash_per  = '0;
        mode.flash = 1'b0;
        mode.led   = 1'b0;
      end
    endcase
    if (c.func != FUNC_TICK) r = leg_duties(time_left >= 0);
    r.rear_led = mode.led;
    r.finished = (time_left <= 0);
    r.locked   = mode.locked;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cmd_t c;
    res_t got;
    res_t exp_w;
    if (!rst_ni) begin
      time_left = '1;
      duty_l    = '0;
      duty_r    = '0;
      mode      = '0;
      flash_cnt = '0;
      flash_per = '0;
      expected_words.delete();
      errors_o        = 0;
      words_checked_o = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got.left_a_duty  = m_tdata_i[7:0];
        got.left_b_duty  = m_tdata_i[15:8];
        got.right_a_duty = m_tdata_i[23:16];
        got.right_b_duty = m_tdata_i[31:24];
        got.rear_led     = m_tdata_i[32];
        got.finished     = m_tdata_i[33];
        got.locked       = m_tdata_i[34];
        if (expected_words.size() == 0) begin
          errors_o++;
          if (errors_o <= 10)
            $display({"%0t: result word with none expected: ",
                      "la=%0d lb=%0d ra=%0d rb=%0d led=%b fin=%b lock=%b"},
                     $time, got.left_a_duty, got.left_b_duty, got.right_a_duty,
                     got.right_b_duty, got.rear_led, got.finished, got.locked);
        end else begin
          exp_w = expected_words.pop_front();
          words_checked_o++;
          if (got.left_a_duty !== exp_w.left_a_duty || got.left_b_duty !== exp_w.left_b_duty ||
              got.right_a_duty !== exp_w.right_a_duty ||
              got.right_b_duty !== exp_w.right_b_duty || got.rear_led !== exp_w.rear_led ||
              got.finished !== exp_w.finished || got.locked !== exp_w.locked) begin
            errors_o++;
            if (errors_o <= 10) begin
              $display("%0t: result word %0d mismatch", $time, words_checked_o);
              $display("  expected la=%0d lb=%0d ra=%0d rb=%0d led=%b fin=%b lock=%b",
                       exp_w.left_a_duty, exp_w.left_b_duty, exp_w.right_a_duty,
                       exp_w.right_b_duty, exp_w.rear_led, exp_w.finished, exp_w.locked);
              $display("  actual   la=%0d lb=%0d ra=%0d rb=%0d led=%b fin=%b lock=%b",
                       got.left_a_duty, got.left_b_duty, got.right_a_duty,
                       got.right_b_duty, got.rear_led, got.finished, got.locked);
            end
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        c.func          = func_e'(s_tuser_i);
        c.duration      = s_tdata_i[15:0];
        c.left_power    = s_tdata_i[23:16];
        c.right_power   = s_tdata_i[31:24];
        c.left_forward  = s_tdata_i[32];
        c.right_forward = s_tdata_i[33];
        c.elapsed       = s_tdata_i[43:34];
        expected_words.push_back(next_motor_word(c));
      end
    end
    pending_o = expected_words.size();
  end

endmodule

// ===== tb/sv/timed_dual_motor_drive_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_dual_motor_drive_test
// Stimulus and verdict for the timed dual motor drive.
// ----------------------------------------------------------------------------
// A directed run of moves, locks, halts and flash commands is followed by
// random command and tick words over four phases of source idling and sink
// stalling, one of them with a long sink hold-off. The checker beside the
// block predicts and compares every result word.
// ----------------------------------------------------------------------------
module timed_dual_motor_drive_test;
  import tdmd_pkg::*;

  localparam int RANDOM_WORDS = 500;
  localparam int HOLD_CYCLES  = 80;
  localparam int LIMIT_CYCLES = 200000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [FUNC_W-1:0]     s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  int errors;
  int pending;
  int words_checked;
  int words_sent;
  int idle_pct;
  int stall_pct;
  int cycle_cnt = 0;
  bit pressure_go;
  bit hold_off;

  always #5 clk_i = ~clk_i;

  timed_dual_motor_drive dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  timed_dual_motor_drive_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_tvalid_i      (s_axis_tvalid),
    .s_tready_i      (s_axis_tready),
    .s_tdata_i       (s_axis_tdata),
    .s_tuser_i       (s_axis_tuser),
    .m_tvalid_i      (m_axis_tvalid),
    .m_tready_i      (m_axis_tready),
    .m_tdata_i       (m_axis_tdata),
    .errors_o        (errors),
    .pending_o       (pending),
    .words_checked_o (words_checked)
  );

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("timed_dual_motor_drive_test NOT OK");
      $finish;
    end
  end

  // sink side
  always @(posedge clk_i)
    m_axis_tready <= !hold_off && ($urandom_range(99) >= stall_pct);

  // long sink hold-off so the block fills and drops s_axis_tready
  initial begin
    hold_off = 1'b0;
    wait (pressure_go);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  function automatic cmd_t mk(func_e f, int dur, int lp, int rp, bit lf, bit rf, int el);
    cmd_t c;
    c.func          = f;
    c.duration      = dur[DUR_W-1:0];
    c.left_power    = lp[POWER_W-1:0];
    c.right_power   = rp[POWER_W-1:0];
    c.left_forward  = lf;
    c.right_forward = rf;
    c.elapsed       = el[ELAPSED_W-1:0];
    return c;
  endfunction

  // half of the words are ticks, mostly with modest elapsed times so moves and flashes run a while
  function automatic cmd_t random_word();
    cmd_t c;
    int   pick;
    pick            = $urandom_range(99);
    c.duration      = DUR_W'($urandom());
    c.left_power    = POWER_W'($urandom());
    c.right_power   = POWER_W'($urandom());
    c.left_forward  = 1'($urandom());
    c.right_forward = 1'($urandom());
    c.elapsed       = ($urandom_range(3) == 0) ? ELAPSED_W'($urandom_range(1023))
                                               : ELAPSED_W'($urandom_range(150));
    if (pick < 50)      c.func = FUNC_TICK;
    else if (pick < 60) c.func = FUNC_FORWARD;
    else if (pick < 68) c.func = FUNC_BACK;
    else if (pick < 80) c.func = FUNC_TURN;
    else if (pick < 84) c.func = FUNC_HALT;
    else if (pick < 90) c.func = FUNC_UNLOCK;
    else if (pick < 96) c.func = FUNC_FLASH_START;
    else                c.func = FUNC_FLASH_STOP;
    if (c.func == FUNC_FLASH_START) begin
      if ($urandom_range(4) != 0) c.duration = DUR_W'($urandom_range(600));
    end else if (c.func != FUNC_TICK) begin
      case ($urandom_range(9))
        0:       ;  // full 16-bit range
        1:       c.duration = DUR_W'(-int'($urandom_range(50)));
        default: c.duration = DUR_W'($urandom_range(2000));
      endcase
    end
    return c;
  endfunction

  task automatic send_word(cmd_t c);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c.func;
    s_axis_tdata  <= {4'b0, c.elapsed, c.right_forward, c.left_forward,
                      c.right_power, c.left_power, c.duration};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    words_sent++;
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FUNC_TICK;
    idle_pct      = 0;
    stall_pct     = 0;
    pressure_go   = 1'b0;
    words_sent    = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle tick, lock refusals, back while locked, extremes, halt, flash
    send_word(mk(FUNC_TICK,        0,      0,   0,   0, 0, 0));
    send_word(mk(FUNC_FORWARD,     100,    255, 3,   0, 0, 0));
    send_word(mk(FUNC_TICK,        0,      0,   0,   0, 0, 0));
    send_word(mk(FUNC_FORWARD,     5,      1,   1,   1, 1, 0));
    send_word(mk(FUNC_TURN,        7,      9,   9,   1, 1, 0));
    send_word(mk(FUNC_TICK,        0,      0,   0,   0, 0, 1023));
    send_word(mk(FUNC_TICK,        0,      0,   0,   0, 0, 5));
    send_word(mk(FUNC_TURN,        32767,  0,   255, 0, 1, 0));
    send_word(mk(FUNC_BACK,        -32768, 128, 0,   0, 0, 0));
    send_word(mk(FUNC_TICK,        -1,     255, 255, 1, 1, 1023));
    send_word(mk(FUNC_BACK,        0,      200, 0,   0, 0, 0));
    send_word(mk(FUNC_TICK,        0,      0,   0,   0, 0, 0));
    send_word(mk(FUNC_UNLOCK,      0,      0,   0,   0, 0, 0));
    send_word(mk(FUNC_TURN,        300,    17,  250, 1, 0, 0));
    send_word(mk(FUNC_HALT,        0,      0,   0,   0, 0, 0));
    send_word(mk(FUNC_FLASH_START, 0,      0,   0,   0, 0, 0));
    send_word(mk(FUNC_TICK,        0,      0,   0,   0, 0, 1));
    send_word(mk(FUNC_TICK,        0,      0,   0,   0, 0, 1));
    send_word(mk(FUNC_FLASH_START, 2,      0,   0,   0, 0, 0));
    send_word(mk(FUNC_TICK,        0,      0,   0,   0, 0, 1023));
    send_word(mk(FUNC_TICK,        0,      0,   0,   0, 0, 0));
    send_word(mk(FUNC_FLASH_STOP,  0,      0,   0,   0, 0, 0));
    send_word(mk(FUNC_FLASH_START, -32768, 0,   0,   0, 0, 0));
    send_word(mk(FUNC_TICK,        0,      0,   0,   0, 0, 1023));
    send_word(mk(FUNC_HALT,        0,      0,   0,   0, 0, 0));

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct    = 0;
          stall_pct   = 0;
          pressure_go = 1'b1;
        end
        1: begin
          idle_pct  = 69;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 69;
        end
        default: begin
          idle_pct  = 16;
          stall_pct = 16;
        end
      endcase
      repeat (RANDOM_WORDS / 4) send_word(random_word());
    end
    s_axis_tvalid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d command and tick words (directed, then random over four idle/stall",
             words_sent);
    $display("phases incl. an %0d-cycle sink hold-off); %0d result words compared.",
             HOLD_CYCLES, words_checked);
    if (errors == 0 && pending == 0) begin
      $display("timed_dual_motor_drive_test OK");
    end else begin
      $display("timed_dual_motor_drive_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/tdmd_pkg.sv
hdl/tdmd_in_stage.sv
hdl/tdmd_core.sv
hdl/tdmd_out_stage.sv
hdl/timed_dual_motor_drive.sv
hdl/tdmd_checker.sv
tb/sv/timed_dual_motor_drive_checker.sv
tb/sv/timed_dual_motor_drive_test.sv
